>>> hdl/cdg_pkg.sv
// Shared types and constants for the central-difference gradient block.
`default_nettype none

package cdg_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int GRAD_W     = PIXEL_BITS + 1;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic            DIR_RESET    = 1'b0;
	localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [FH_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [FW_W-1:0] MIN_WIDTH    = 11'd3;
	localparam logic [FH_W-1:0] MIN_HEIGHT   = 12'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION    = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel;
		logic                         frame_start;
	} pix_item_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         column;
		logic                     last_of_run;
		logic                     end_of_frame;
	} grad_item_t;

	typedef struct packed {
		logic            direction;
		logic [FW_W-1:0] frame_width;
		logic [FH_W-1:0] frame_height;
	} cfg_t;

	// One queue entry describes all results caused by one pixel.
	typedef struct packed {
		logic signed [GRAD_W-1:0] grad;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         column;
		logic                     mode_y;
		logic                     has_first;
		logic                     has_second;
		logic                     second_eof;
	} entry_t;

	typedef struct packed {
		logic full;
		logic near_full;
	} fifo_status_t;

endpackage

`default_nettype wire

>>> hdl/central_difference_gradient.sv
// A pixel's first result beat passes the stage-1 registers, the queue and then the output register.
// Throughput: one pixel per cycle while pix_stall is low; a pixel with two results (row end in x,
// last row in y) sends both its beats through the output register, and a four-entry queue absorbs it.
// Row stores are block RAMs of MAX_WIDTH entries, read when a pixel is taken.
// Reset (arst_n low, asynchronous) clears counters, history, queue and output valid.
`default_nettype none

module central_difference_gradient #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [cdg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [cdg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                              pix_valid,
	output logic                             pix_stall,
	input  cdg_pkg::pix_item_t               pix_item,
	output logic                             grad_valid,
	input  wire                              grad_stall,
	output cdg_pkg::grad_item_t              grad_item
);
	import cdg_pkg::*;

	cfg_t         cfg_q;
	logic         push;
	entry_t       push_data;
	entry_t       head;
	logic         empty;
	logic         pop;
	fifo_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction    <= DIR_RESET;
			cfg_q.frame_width  <= WIDTH_RESET;
			cfg_q.frame_height <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION:    cfg_q.direction    <= cfg_data[0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	cdg_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_item  (pix_item),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	cdg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.status    (q_status)
	);

	cdg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.grad_valid (grad_valid),
		.grad_stall (grad_stall),
		.grad_item  (grad_item)
	);

endmodule

`default_nettype wire

>>> hdl/cdg_front.sv
// Front part: accepts pixels, tracks position, keeps pixel history and row stores.
`default_nettype none

module cdg_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cdg_pkg::cfg_t         cfg,
	input  wire                   pix_valid,
	output logic                  pix_stall,
	input  cdg_pkg::pix_item_t    pix_item,
	input  cdg_pkg::fifo_status_t q_status,
	output logic                  push,
	output cdg_pkg::entry_t       push_data
);
	import cdg_pkg::*;

	localparam int IDX_W  = $clog2(MAX_WIDTH);
	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
	localparam int CNT_W  = (WCNT_W > FW_W) ? WCNT_W : FW_W;

	logic                  accept;
	logic [CNT_W-1:0]      fw_ext;
	logic [CNT_W-1:0]      w_clamp;
	logic [CNT_W-1:0]      w_last;
	logic [FH_W-1:0]       h_last;
	logic [CNT_W-1:0]      c_raw;
	logic [CNT_W-1:0]      c_cur;
	logic [ROW_W-1:0]      r_raw;
	logic [ROW_W-1:0]      r_cur;
	logic [IDX_W-1:0]      c_idx;
	logic                  row_end;
	logic                  frame_end;

	logic [IDX_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [PIXEL_BITS-1:0] prev_q;
	logic [PIXEL_BITS-1:0] sprev_q;

	logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] older_rd_s1;
	logic [PIXEL_BITS-1:0] newer_rd_s1;

	logic                  s1_valid_q;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [PIXEL_BITS-1:0] sprev_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [COL_W-1:0]      col_s1;
	logic                  mode_y_s1;
	logic                  has_first_s1;
	logic                  zero_first_s1;
	logic                  has_second_s1;
	logic                  second_eof_s1;
	logic                  byp_s1;
	logic [PIXEL_BITS-1:0] byp_older_s1;
	logic [PIXEL_BITS-1:0] byp_newer_s1;

	logic [PIXEL_BITS-1:0] older_fwd;
	logic [PIXEL_BITS-1:0] newer_fwd;
	logic [PIXEL_BITS-1:0] ref_pix;
	logic signed [GRAD_W-1:0] diff;

	// The queue must hold the item in flight plus the one taken now.
	assign pix_stall = q_status.full || (q_status.near_full && s1_valid_q);
	assign accept    = pix_valid && !pix_stall;

	always_comb begin
		fw_ext = CNT_W'(cfg.frame_width);
		if (fw_ext < CNT_W'(MIN_WIDTH)) begin
			w_clamp = CNT_W'(MIN_WIDTH);
		end else if (fw_ext > CNT_W'(MAX_WIDTH)) begin
			w_clamp = CNT_W'(MAX_WIDTH);
		end else begin
			w_clamp = fw_ext;
		end
		w_last = w_clamp - CNT_W'(1);
		h_last = ((cfg.frame_height < MIN_HEIGHT) ? MIN_HEIGHT : cfg.frame_height) - FH_W'(1);

		c_raw = pix_item.frame_start ? '0 : CNT_W'(col_q);
		r_raw = pix_item.frame_start ? '0 : row_q;
		c_cur = (c_raw > w_last) ? w_last : c_raw;
		r_cur = (r_raw > h_last) ? h_last : r_raw;
		c_idx = c_cur[IDX_W-1:0];
		row_end   = (c_cur == w_last);
		frame_end = (r_cur == h_last);
	end

	// Position counters and horizontal pixel history, in input order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prev_q  <= '0;
			sprev_q <= '0;
		end else if (accept) begin
			sprev_q <= prev_q;
			prev_q  <= pix_item.pixel;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : r_cur + ROW_W'(1);
			end else begin
				col_q <= IDX_W'(c_cur + CNT_W'(1));
				row_q <= r_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1        <= pix_item.pixel;
			sprev_s1      <= sprev_q;
			idx_s1        <= c_idx;
			row_s1        <= r_cur;
			col_s1        <= COL_W'(c_cur);
			mode_y_s1     <= cfg.direction;
			has_first_s1  <= cfg.direction ? (r_cur != '0) : (c_cur != '0);
			zero_first_s1 <= cfg.direction ? (r_cur == ROW_W'(1)) : (c_cur == CNT_W'(1));
			has_second_s1 <= cfg.direction ? frame_end : row_end;
			second_eof_s1 <= cfg.direction ? row_end : frame_end;
			// The store write of the item in flight lands after this read.
			byp_s1        <= s1_valid_q && (idx_s1 == c_idx);
			byp_older_s1  <= newer_fwd;
			byp_newer_s1  <= pix_s1;
		end
	end

	// Row stores: read at the accepted column, rewritten in the cycle after the read.
	always_ff @(posedge clk) begin
		if (accept) begin
			older_rd_s1 <= older_mem[c_idx];
			newer_rd_s1 <= newer_mem[c_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			older_mem[idx_s1] <= newer_fwd;
			newer_mem[idx_s1] <= pix_s1;
		end
	end

	assign older_fwd = byp_s1 ? byp_older_s1 : older_rd_s1;
	assign newer_fwd = byp_s1 ? byp_newer_s1 : newer_rd_s1;

	assign ref_pix = mode_y_s1 ? older_fwd : sprev_s1;
	assign diff    = $signed({pix_s1[PIXEL_BITS-1], pix_s1})
	               - $signed({ref_pix[PIXEL_BITS-1], ref_pix});

	always_comb begin
		push_data.grad       = zero_first_s1 ? '0 : diff;
		push_data.row        = row_s1;
		push_data.column     = col_s1;
		push_data.mode_y     = mode_y_s1;
		push_data.has_first  = has_first_s1;
		push_data.has_second = has_second_s1;
		push_data.second_eof = second_eof_s1;
	end

	assign push = s1_valid_q && (has_first_s1 || has_second_s1);

	a_zero_only_first : assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && zero_first_s1 |-> has_first_s1)
		else $error("border zero flagged on an item without a first result");

	a_no_take_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !accept)
		else $error("pixel taken while the queue is full");

endmodule

`default_nettype wire

>>> hdl/cdg_fifo.sv
// Short queue between the front and back parts, at most one entry per pixel.
`default_nettype none

module cdg_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  cdg_pkg::entry_t       push_data,
	input  wire                   pop,
	output cdg_pkg::entry_t       head,
	output logic                  empty,
	output cdg_pkg::fifo_status_t status
);
	import cdg_pkg::*;

	entry_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign empty            = (count_q == '0);
	assign do_pop           = pop && !empty;
	assign head             = entry_q[rd_ptr_q];
	assign status.full      = (count_q == QCNT_W'(QDEPTH));
	assign status.near_full = (count_q >= QCNT_W'(QDEPTH - 1));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_W'(QDEPTH)))
		else $error("queue push while full");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> hdl/cdg_back.sv
// Back part: expands queue entries into result beats behind an output register.
`default_nettype none

module cdg_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cdg_pkg::entry_t     head,
	input  wire                 empty,
	output logic                pop,
	output logic                grad_valid,
	input  wire                 grad_stall,
	output cdg_pkg::grad_item_t grad_item
);
	import cdg_pkg::*;

	logic       first_sent_q;
	logic       valid_q;
	grad_item_t item_q;
	logic       load;
	logic       cur_first;
	logic       entry_done;
	grad_item_t res;

	assign load       = !valid_q || !grad_stall;
	assign cur_first  = head.has_first && !first_sent_q;
	assign entry_done = !(cur_first && head.has_second);
	assign pop        = load && !empty && entry_done;

	always_comb begin
		if (cur_first) begin
			res.gradient     = head.grad;
			res.row          = head.mode_y ? head.row - ROW_W'(1) : head.row;
			res.column       = head.mode_y ? head.column : head.column - COL_W'(1);
			res.last_of_run  = !head.has_second;
			res.end_of_frame = 1'b0;
		end else begin
			res.gradient     = '0;
			res.row          = head.row;
			res.column       = head.column;
			res.last_of_run  = 1'b1;
			res.end_of_frame = head.second_eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			first_sent_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				first_sent_q <= !entry_done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			item_q <= res;
		end
	end

	assign grad_valid = valid_q;
	assign grad_item  = item_q;

	a_eof_is_last : assert property (@(posedge clk) disable iff (!arst_n)
		grad_valid && grad_item.end_of_frame |-> grad_item.last_of_run)
		else $error("end of frame on a beat that is not last of its run");

	a_split_entry : assert property (@(posedge clk) disable iff (!arst_n)
		first_sent_q |-> (!empty && head.has_first && head.has_second))
		else $error("second beat pending without a two-result entry");

endmodule

`default_nettype wire
